// ===== rtl/bba_pkg.sv =====
// Shared constants, types and helpers of the buddy block allocator.
package bba_pkg;

	localparam int POOL_BLOCKS = 1024;
	localparam int MAX_ORDER   = 10;
	localparam int IDX_W       = 10;
	localparam int LINK_W      = 11;
	localparam int ORD_W       = 4;
	localparam int CNT_W       = 11;

	localparam logic [LINK_W-1:0] NIL_BLOCK = LINK_W'(POOL_BLOCKS);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REBUILD = 2'd2
	} op_t;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_A_SCAN   = 10'b0000000010,
		S_A_POP    = 10'b0000000100,
		S_A_SPLIT  = 10'b0000001000,
		S_R_CHK    = 10'b0000010000,
		S_R_WALK   = 10'b0000100000,
		S_R_NEXT   = 10'b0001000000,
		S_R_UNLINK = 10'b0010000000,
		S_B_NEXT   = 10'b0100000000,
		S_DONE     = 10'b1000000000
	} state_t;

	// ceil(log2(n)), zero for n of 0 or 1
	function automatic logic [ORD_W-1:0] order_of(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] m;
		logic [ORD_W-1:0] k;
		m = n - CNT_W'(1);
		k = '0;
		if (n > CNT_W'(1)) begin
			for (int i = 0; i < CNT_W; i++) begin
				if (m[i]) begin
					k = ORD_W'(i + 1);
				end
			end
		end
		return k;
	endfunction

endpackage

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator: free lists per order, walked by a single sequencer.
// Alloc pops a block and releases one upper half per split level; free walks a free list per
// merge level; rebuild does one release per usable block; one request in flight at a time.
// Each list step reads the next-link memory (S_R_WALK) and then takes the read link (S_R_NEXT).
// Result sits in an output register; a new request is taken once the sequencer is idle.
// Reset: all lists empty, top order zero, usable_blocks 1024; link memory is not cleared.
module buddy_block_allocator import bba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // op[1:0], block_count[12:2], block_index[22:13]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // ok[0], granted_index[10:1], granted_order[14:11]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t             state_q;
	logic [CNT_W-1:0]   usable_q;
	logic [ORD_W-1:0]   top_q;
	logic [LINK_W-1:0]  head_q [0:MAX_ORDER];
	logic [LINK_W-1:0]  link_mem [0:POOL_BLOCKS-1];
	logic [LINK_W-1:0]  rd_q;

	logic [1:0]         op_q;
	logic [ORD_W-1:0]   level_q, t_q, k_q, lev_q;
	logic [IDX_W-1:0]   start_q;
	logic [LINK_W-1:0]  addr_q, bud_q, cur_q, prev_q;
	logic               odd_q;
	logic [CNT_W-1:0]   steps_q, i_q, n_q;
	logic               res_ok_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic [ORD_W-1:0]   res_ord_q;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	logic               mem_we, mem_re;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [LINK_W-1:0]  mem_wdata;

	logic [1:0]         in_op;
	logic [CNT_W-1:0]   in_count;
	logic [IDX_W-1:0]   in_index;
	logic [ORD_W-1:0]   in_order;
	logic [CNT_W-1:0]   clamp_n;
	logic [ORD_W-1:0]   clamp_ord;
	logic [LINK_W-1:0]  idx_w;
	logic               walk_end;
	logic               cfg_wr;

	assign in_op    = s_tdata[1:0];
	assign in_count = s_tdata[12:2];
	assign in_index = s_tdata[22:13];
	assign in_order = order_of(in_count);
	assign clamp_n  = (usable_q > CNT_W'(POOL_BLOCKS)) ? CNT_W'(POOL_BLOCKS) : usable_q;
	assign clamp_ord = (order_of(clamp_n) > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
		: order_of(clamp_n);
	assign idx_w    = addr_q >> lev_q;
	assign walk_end = (steps_q == CNT_W'(POOL_BLOCKS)) || (cur_q >= NIL_BLOCK);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == 1'b0) ? {21'd0, usable_q} : 32'd0;

	function automatic state_t ret_state(input logic [1:0] op);
		state_t s;
		case (op)
			OP_ALLOC:   s = S_A_SPLIT;
			OP_REBUILD: s = S_B_NEXT;
			default:    s = S_DONE;
		endcase
		return s;
	endfunction

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q[IDX_W-1:0];
		mem_wdata = head_q[lev_q];
		mem_re    = 1'b0;
		mem_raddr = cur_q[IDX_W-1:0];
		unique case (state_q)
			S_A_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = head_q[t_q][IDX_W-1:0];
			end
			S_R_CHK: begin
				mem_we = (addr_q < NIL_BLOCK) && (lev_q == ORD_W'(MAX_ORDER));
			end
			S_R_WALK: begin
				mem_we = walk_end;
				mem_re = !walk_end;
			end
			S_R_UNLINK: begin
				mem_we    = (prev_q != NIL_BLOCK);
				mem_waddr = prev_q[IDX_W-1:0];
				mem_wdata = rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= link_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= CNT_W'(1024);
		end else if (cfg_wr && paddr[2] == 1'b0) begin
			usable_q <= pwdata[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			top_q      <= '0;
			m_tvalid_q <= 1'b0;
			for (int j = 0; j <= MAX_ORDER; j++) begin
				head_q[j] <= NIL_BLOCK;
			end
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q      <= in_op;
						res_ok_q  <= 1'b0;
						res_idx_q <= '0;
						res_ord_q <= '0;
						state_q   <= S_DONE;
						case (in_op)
							OP_ALLOC: begin
								level_q <= in_order;
								t_q     <= in_order;
								if (in_order <= top_q) begin
									state_q <= S_A_SCAN;
								end
							end
							OP_FREE: begin
								if (in_order <= ORD_W'(MAX_ORDER)) begin
									res_ok_q <= 1'b1;
									addr_q   <= {1'b0, in_index};
									lev_q    <= in_order;
									state_q  <= S_R_CHK;
								end
							end
							OP_REBUILD: begin
								res_ok_q <= 1'b1;
								n_q      <= clamp_n;
								i_q      <= '0;
								top_q    <= clamp_ord;
								for (int j = 0; j <= MAX_ORDER; j++) begin
									head_q[j] <= NIL_BLOCK;
								end
								state_q <= S_B_NEXT;
							end
							default: begin
							end
						endcase
					end
				end
				S_A_SCAN: begin
					if (t_q > top_q) begin
						state_q <= S_DONE;
					end else if (head_q[t_q] != NIL_BLOCK) begin
						start_q <= head_q[t_q][IDX_W-1:0];
						state_q <= S_A_POP;
					end else begin
						t_q <= t_q + ORD_W'(1);
					end
				end
				S_A_POP: begin
					head_q[t_q] <= rd_q;
					k_q         <= t_q;
					state_q     <= S_A_SPLIT;
				end
				S_A_SPLIT: begin
					if (k_q > level_q) begin
						addr_q  <= {1'b0, start_q} + (LINK_W'(1) << (k_q - ORD_W'(1)));
						lev_q   <= k_q - ORD_W'(1);
						k_q     <= k_q - ORD_W'(1);
						state_q <= S_R_CHK;
					end else begin
						res_ok_q  <= 1'b1;
						res_idx_q <= start_q;
						res_ord_q <= level_q;
						state_q   <= S_DONE;
					end
				end
				S_R_CHK: begin
					if (addr_q >= NIL_BLOCK || lev_q > ORD_W'(MAX_ORDER)) begin
						state_q <= ret_state(op_q);
					end else if (lev_q == ORD_W'(MAX_ORDER)) begin
						head_q[lev_q] <= addr_q;
						state_q       <= ret_state(op_q);
					end else begin
						bud_q   <= (idx_w ^ LINK_W'(1)) << lev_q;
						odd_q   <= idx_w[0];
						cur_q   <= head_q[lev_q];
						prev_q  <= NIL_BLOCK;
						steps_q <= '0;
						state_q <= S_R_WALK;
					end
				end
				S_R_WALK: begin
					if (walk_end) begin
						head_q[lev_q] <= addr_q;
						state_q       <= ret_state(op_q);
					end else if (cur_q == bud_q) begin
						state_q <= S_R_UNLINK;
					end else begin
						prev_q  <= cur_q;
						steps_q <= steps_q + CNT_W'(1);
						state_q <= S_R_NEXT;
					end
				end
				S_R_NEXT: begin
					cur_q   <= rd_q;
					state_q <= S_R_WALK;
				end
				S_R_UNLINK: begin
					if (head_q[lev_q] == cur_q) begin
						head_q[lev_q] <= rd_q;
					end
					if (odd_q) begin
						addr_q <= bud_q;
					end
					lev_q   <= lev_q + ORD_W'(1);
					state_q <= S_R_CHK;
				end
				S_B_NEXT: begin
					if (i_q < n_q) begin
						addr_q  <= i_q;
						lev_q   <= '0;
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_R_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, res_ord_q, res_idx_q, res_ok_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[14:1] == 14'd0)
		else $error("failed result carries a grant");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_R_WALK |-> steps_q <= CNT_W'(POOL_BLOCKS) && lev_q < ORD_W'(MAX_ORDER))
		else $error("list walk out of bounds");

	a_grant_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && res_ok_q && op_q == OP_ALLOC |-> res_ord_q <= top_q)
		else $error("grant above top order");

	a_unlink_prev: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_R_UNLINK |-> $past(state_q) == S_R_WALK && cur_q == bud_q)
		else $error("unlink without a buddy match");

endmodule
